[rtl/core/lpqs_pkg.sv]
// Package for the quarter-scan LED panel scan-out engine.
// Holds the transaction payload types, the mode and register codes and sizing constants.
// Depends on nothing else.
package lpqs_pkg;

   localparam int DEF_MAX_PANELS_WIDE = 8;
   localparam int DEF_MAX_PANELS_HIGH = 4;
   localparam int PANEL_ROWS          = 16;

   // Request modes.
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_EMIT  = 2'd1;
   localparam logic [1:0] MODE_SWAP  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PANELS_WIDE   = 2'd0;
   localparam logic [1:0] CSR_PANELS_HIGH   = 2'd1;
   localparam logic [1:0] CSR_DOUBLE_BUFFER = 2'd2;

   localparam logic [7:0] BLANK_BYTE = 8'hFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] byte_address;
      logic [7:0]  pixel_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] shift_byte;
      logic [1:0] row_select;
      logic       latch_strobe;
   } rsp_type;

   function automatic logic [7:0] reverse8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

endpackage

[rtl/core/led_panel_quarter_scan_out.sv]
// Scan-out engine for tiled 32x16 LED panels driven with 1/4 scan.
// Holds the frame store memory, scan position and the output register.
// Depends on lpqs_pkg.
//
//   port group  direction  handshake          payload
//   req_*       in         req_valid/req_stall lpqs_pkg::req_type
//   rsp_*       out        rsp_valid/rsp_stall lpqs_pkg::rsp_type
//   csr_*       in         csr_valid/csr_ready csr_index, csr_data
//
// One transaction is taken per clock while req_stall is low; each is at most one access to
// the frame store port, and an emitted byte passes through rd_data_ff and the output
// register before it is presented on rsp_*. After reset the whole frame store is swept
// to 0xFF, and turning double buffering on sweeps the upper half; no request is taken
// during a sweep. A stalled result is held in the output register while one more emit
// request enters behind it (writes and swaps still pass until then); after that
// req_stall follows rsp_stall.
module led_panel_quarter_scan_out #(
   parameter int MAX_PANELS_WIDE = lpqs_pkg::DEF_MAX_PANELS_WIDE,
   parameter int MAX_PANELS_HIGH = lpqs_pkg::DEF_MAX_PANELS_HIGH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpqs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpqs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data
);

   localparam int HALF   = MAX_PANELS_WIDE * 4 * MAX_PANELS_HIGH * lpqs_pkg::PANEL_ROWS;
   localparam int DEPTH  = 2 * HALF;
   localparam int HALF_W = $clog2(HALF);
   localparam int MA_W   = $clog2(DEPTH);
   localparam int WE_W   = $clog2(MAX_PANELS_WIDE + 1);
   localparam int ST_W   = WE_W + 2;
   localparam int HE_W   = $clog2(MAX_PANELS_HIGH + 1);
   localparam int GW     = (MAX_PANELS_HIGH > 1) ? $clog2(MAX_PANELS_HIGH) : 1;
   localparam int CW     = $clog2(4 * MAX_PANELS_WIDE);
   localparam int RW     = GW + 4;
   localparam int PW     = RW + ST_W;
   localparam int MW     = HALF_W + 5;

   // Write address folded into one buffer half by five restoring compare-subtract steps.
   function automatic logic [HALF_W-1:0] fold_address(input logic [10:0] a);
      logic [MW-1:0] r;
      logic [MW-1:0] half_v;
      r      = MW'(a);
      half_v = MW'(HALF);
      for (int k = 4; k >= 0; k--) begin
         if (r >= (half_v << k)) begin
            r = r - (half_v << k);
         end
      end
      return HALF_W'(r);
   endfunction

   // Configuration and buffer selection.
   logic [3:0]    panels_wide_ff;
   logic [2:0]    panels_high_ff;
   logic          double_buffer_ff;
   logic          display_ff;

   // Scan position.
   logic [1:0]    phase_ff, phase_in;
   logic [GW-1:0] group_ff, group_in;
   logic [CW-1:0] column_ff, column_in;
   logic [1:0]    lane_ff, lane_in;

   // Clearing sweep.
   logic          clearing_ff;
   logic [MA_W-1:0] clr_addr_ff;

   // Memory and pipeline.
   logic [7:0]    frame_mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_flip_ff;
   logic [1:0]    s1_sel_ff;
   logic          s1_latch_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   lpqs_pkg::rsp_type rsp_data_ff;

   logic          accept, is_write, is_emit, is_swap, s1_adv, csr_wr;
   logic [WE_W-1:0] wide_eff;
   logic [HE_W-1:0] high_eff;
   logic [ST_W-1:0] stride;
   logic          flipped, last_lane, last_col, last_group, latch_now;
   logic [RW-1:0] row;
   logic [CW-1:0] col;
   logic [PW-1:0] prod;
   logic [HALF_W-1:0] pos;
   logic [HALF_W-1:0] wr_pos;
   logic          draw_half;
   logic [MA_W-1:0] rd_addr, wr_addr, mem_addr;
   logic          mem_we, mem_re;
   logic [7:0]    mem_wdata;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_write  = accept && (req_data.mode == lpqs_pkg::MODE_WRITE);
   assign is_emit   = accept && (req_data.mode == lpqs_pkg::MODE_EMIT);
   assign is_swap   = accept && (req_data.mode == lpqs_pkg::MODE_SWAP);

   // Effective panel counts: zero reads as one, oversized values saturate.
   always_comb begin
      if (panels_wide_ff == 4'd0) begin
         wide_eff = WE_W'(1);
      end else if (int'(panels_wide_ff) > MAX_PANELS_WIDE) begin
         wide_eff = WE_W'(MAX_PANELS_WIDE);
      end else begin
         wide_eff = WE_W'(panels_wide_ff);
      end
      if (panels_high_ff == 3'd0) begin
         high_eff = HE_W'(1);
      end else if (int'(panels_high_ff) > MAX_PANELS_HIGH) begin
         high_eff = HE_W'(MAX_PANELS_HIGH);
      end else begin
         high_eff = HE_W'(panels_high_ff);
      end
   end

   assign stride = {wide_eff, 2'b00};

   // A group is upside down when panel count plus group index is even.
   assign flipped = (high_eff[0] == group_ff[0]);

   // Four interleaved rows per panel group; the low row bits are lane and phase.
   always_comb begin
      if (flipped) begin
         row = {group_ff, lane_ff, ~phase_ff};
         col = CW'(stride - ST_W'(1) - ST_W'(column_ff));
      end else begin
         row = {group_ff, ~lane_ff, phase_ff};
         col = column_ff;
      end
      prod = PW'(row) * PW'(stride);
      pos  = HALF_W'(prod + PW'(col));
   end

   assign rd_addr   = display_ff ? (MA_W'(pos) + MA_W'(HALF)) : MA_W'(pos);
   assign wr_pos    = fold_address(req_data.byte_address);
   assign draw_half = double_buffer_ff && !display_ff;
   assign wr_addr   = draw_half ? (MA_W'(wr_pos) + MA_W'(HALF)) : MA_W'(wr_pos);

   assign mem_we    = clearing_ff || is_write;
   assign mem_re    = is_emit;
   assign mem_addr  = clearing_ff ? clr_addr_ff : (is_write ? wr_addr : rd_addr);
   assign mem_wdata = clearing_ff ? lpqs_pkg::BLANK_BYTE : req_data.pixel_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_addr];
      end
   end

   // Scan position advance.
   assign last_lane  = (lane_ff == 2'd3);
   assign last_col   = (ST_W'(column_ff) == stride - ST_W'(1));
   assign last_group = (int'(group_ff) == int'(high_eff) - 1);
   assign latch_now  = last_lane && last_col && last_group;

   always_comb begin
      phase_in  = phase_ff;
      group_in  = group_ff;
      column_in = column_ff;
      lane_in   = lane_ff;
      if (csr_wr && (csr_index == lpqs_pkg::CSR_PANELS_WIDE ||
                     csr_index == lpqs_pkg::CSR_PANELS_HIGH)) begin
         group_in  = '0;
         column_in = '0;
         lane_in   = '0;
      end else if (is_emit) begin
         lane_in = lane_ff + 2'd1;
         if (last_lane) begin
            if (last_col) begin
               column_in = '0;
               if (last_group) begin
                  group_in = '0;
                  phase_in = phase_ff + 2'd1;
               end else begin
                  group_in = group_ff + GW'(1);
               end
            end else begin
               column_in = column_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         group_ff  <= '0;
         column_ff <= '0;
         lane_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         group_ff  <= group_in;
         column_ff <= column_in;
         lane_ff   <= lane_in;
      end
   end

   // Configuration registers, buffer selection and the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         panels_wide_ff   <= 4'd1;
         panels_high_ff   <= 3'd1;
         double_buffer_ff <= 1'b0;
         display_ff       <= 1'b0;
         clearing_ff      <= 1'b1;
         clr_addr_ff      <= '0;
      end else begin
         if (clearing_ff) begin
            if (clr_addr_ff == MA_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + MA_W'(1);
         end
         if (is_swap && double_buffer_ff) begin
            display_ff <= !display_ff;
         end
         if (csr_wr) begin
            case (csr_index)
               lpqs_pkg::CSR_PANELS_WIDE: begin
                  panels_wide_ff <= csr_data;
               end
               lpqs_pkg::CSR_PANELS_HIGH: begin
                  panels_high_ff <= csr_data[2:0];
               end
               lpqs_pkg::CSR_DOUBLE_BUFFER: begin
                  if (csr_data[0] != double_buffer_ff) begin
                     double_buffer_ff <= csr_data[0];
                     display_ff       <= 1'b0;
                     // A sweep already in the lower half will reach the upper half anyway.
                     if (csr_data[0] && (!clearing_ff || clr_addr_ff >= MA_W'(HALF))) begin
                        clearing_ff <= 1'b1;
                        clr_addr_ff <= MA_W'(HALF);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Read stage and output register.
   always_comb begin
      if (is_emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_emit) begin
         s1_flip_ff  <= flipped;
         s1_sel_ff   <= phase_ff;
         s1_latch_ff <= latch_now;
      end
      if (s1_adv) begin
         rsp_data_ff.shift_byte   <= s1_flip_ff ? lpqs_pkg::reverse8(rd_data_ff) : rd_data_ff;
         rsp_data_ff.row_select   <= s1_sel_ff;
         rsp_data_ff.latch_strobe <= s1_latch_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/lpqs_scan_checker.sv]
// Self-checking monitor for the quarter-scan LED panel scan-out engine.
// Tracks register writes, predicts every shift byte and compares results as they leave.
// Depends on lpqs_pkg.
module lpqs_scan_checker
   import lpqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data,
   output int      mismatches,
   output int      outstanding
);

   localparam int HALF = DEF_MAX_PANELS_WIDE * 4 * DEF_MAX_PANELS_HIGH * PANEL_ROWS;

   logic [7:0] pixel_mirror [2*HALF];
   logic       shown_half;
   logic       dbl_on;
   logic [1:0] scan_ph;
   logic [3:0] wide_reg;
   logic [2:0] high_reg;
   int         grp;
   int         col;
   int         lane;
   int         errors = 0;
   rsp_type    shift_q [$];

   function automatic int clamp_count(input int v, input int most);
      if (v < 1) return 1;
      if (v > most) return most;
      return v;
   endfunction

   task automatic apply_csr(input logic [1:0] idx, input logic [3:0] val);
      case (idx)
         CSR_PANELS_WIDE: begin
            wide_reg = val;
            grp = 0;
            col = 0;
            lane = 0;
         end
         CSR_PANELS_HIGH: begin
            high_reg = val[2:0];
            grp = 0;
            col = 0;
            lane = 0;
         end
         CSR_DOUBLE_BUFFER: begin
            if (val[0] != dbl_on) begin
               dbl_on = val[0];
               if (val[0]) begin
                  for (int i = HALF; i < 2*HALF; i++) pixel_mirror[i] = BLANK_BYTE;
               end
               shown_half = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // Works out the next shift byte and moves the scan position on.
   task automatic scan_next();
      int         stride;
      int         groups;
      int         row;
      int         c;
      int         pos;
      logic       flip;
      logic [7:0] b;
      rsp_type    r;
      stride = clamp_count(int'(wide_reg), DEF_MAX_PANELS_WIDE) * 4;
      groups = clamp_count(int'(high_reg), DEF_MAX_PANELS_HIGH);
      flip = ((groups + grp) % 2) == 0;
      if (!flip) begin
         row = grp * PANEL_ROWS + int'(scan_ph) + 4 * (3 - lane);
         c = col;
      end else begin
         row = grp * PANEL_ROWS + 3 - int'(scan_ph) + 4 * lane;
         c = stride - 1 - col;
      end
      pos = (row * stride + c) % HALF;
      b = pixel_mirror[int'(shown_half) * HALF + pos];
      if (flip) b = {<<{b}};
      r.shift_byte = b;
      r.row_select = scan_ph;
      r.latch_strobe = 1'b0;
      lane++;
      if (lane >= 4) begin
         lane = 0;
         col++;
         if (col >= stride) begin
            col = 0;
            grp++;
            if (grp >= groups) begin
               grp = 0;
               r.latch_strobe = 1'b1;
               scan_ph = scan_ph + 2'd1;
            end
         end
      end
      shift_q.push_back(r);
   endtask

   task automatic take_request(input req_type t);
      logic draw;
      draw = dbl_on ? ~shown_half : 1'b0;
      case (t.mode)
         MODE_WRITE: pixel_mirror[int'(draw) * HALF + int'(t.byte_address) % HALF] = t.pixel_byte;
         MODE_SWAP:  if (dbl_on) shown_half = ~shown_half;
         MODE_EMIT:  scan_next();
         default: ;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (shift_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected result byte=%h sel=%0d latch=%0b", $time,
                  got.shift_byte, got.row_select, got.latch_strobe);
      end else begin
         want = shift_q.pop_front();
         if (got.shift_byte !== want.shift_byte || got.row_select !== want.row_select ||
             got.latch_strobe !== want.latch_strobe) begin
            errors++;
            $display("%0t: expected byte=%h sel=%0d latch=%0b, got byte=%h sel=%0d latch=%0b",
                     $time, want.shift_byte, want.row_select, want.latch_strobe,
                     got.shift_byte, got.row_select, got.latch_strobe);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2*HALF; i++) pixel_mirror[i] = BLANK_BYTE;
         shown_half = 1'b0;
         dbl_on = 1'b0;
         scan_ph = 2'd0;
         wide_reg = 4'd1;
         high_reg = 3'd1;
         grp = 0;
         col = 0;
         lane = 0;
         shift_q.delete();
      end else begin
         // A result leaving now was predicted when its request was accepted, so check it first.
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         if (req_valid && !req_stall) take_request(req_data);
      end
      mismatches <= errors;
      outstanding <= shift_q.size();
   end

endmodule

[bench/testbench.sv]
// Top of the bench for the quarter-scan LED panel scan-out engine.
// Drives requests and register writes, stalls the result side and reports the verdict.
// Depends on lpqs_pkg, led_panel_quarter_scan_out and lpqs_scan_checker.
module testbench;
   import lpqs_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int PHASES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_data = '0;
   int         mismatches;
   int         outstanding;
   int         burst_left = 0;
   int         hold_requests = 0;

   // Raw register values per phase; zero and oversized counts are deliberate.
   int phase_wide  [PHASES] = '{1, 2, 1, 0, 15, 3, 9, 2};
   int phase_high  [PHASES] = '{1, 1, 2, 0, 15, 3, 12, 10};
   int phase_dbl   [PHASES] = '{0, 1, 9, 8, 15, 0, 3, 14};
   int phase_items [PHASES] = '{200, 250, 250, 200, 200, 200, 200, 200};

   led_panel_quarter_scan_out dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   lpqs_scan_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #3000000;
      $display("led_panel_quarter_scan_out test failed");
      $finish;
   end

   // Offers one transaction, opening a new burst after a random gap when the last one ran out.
   task automatic offer(input req_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
   endtask

   // Waits until every predicted byte has left and the pipeline has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [3:0] w, input logic [3:0] h, input logic [3:0] d);
      logic [1:0] idx [4];
      logic [3:0] val [4];
      idx = '{CSR_PANELS_WIDE, CSR_PANELS_HIGH, CSR_DOUBLE_BUFFER, CSR_UNUSED};
      val = '{w, h, d, 4'($urandom_range(0, 15))};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly writes inside the visible frame and emits, with some stray addresses,
   // swaps and the unused mode mixed in.
   function automatic req_type make_item(input int frame_bytes);
      req_type t;
      int      pick;
      t.mode = MODE_EMIT;
      t.byte_address = 11'($urandom_range(0, 2047));
      t.pixel_byte = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         t.mode = MODE_WRITE;
         t.byte_address = 11'($urandom_range(0, frame_bytes - 1));
      end else if (pick < 47) begin
         t.mode = MODE_WRITE;
      end else if (pick < 53) begin
         t.mode = MODE_SWAP;
      end else if (pick < 56) begin
         t.mode = MODE_UNUSED;
      end
      return t;
   endfunction

   initial begin : result_side
      int kind;
      int seg;
      int served;
      served = 0;
      forever begin
         if (hold_requests > served) begin
            // Long hold-off so the block fills up and pushes back on requests.
            served++;
            rsp_stall <= 1'b1;
            repeat ($urandom_range(200, 400)) @(posedge clock);
         end else begin
            kind = $urandom_range(0, 3);
            seg = $urandom_range(10, 80);
            repeat (seg) begin
               case (kind)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      req_type t;
      int      eff_w;
      int      eff_h;
      int      done_items;
      logic    dbl;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // With one panel the first column is read from rows 12, 8, 4 and 0.
      offer(req_type'{MODE_WRITE, 11'd48, 8'h01});
      offer(req_type'{MODE_WRITE, 11'd32, 8'h80});
      offer(req_type'{MODE_WRITE, 11'd16, 8'hA5});
      offer(req_type'{MODE_WRITE, 11'd0, 8'h00});
      offer(req_type'{MODE_WRITE, 11'd2047, 8'h5A});
      offer(req_type'{MODE_WRITE, 11'd1024, 8'h00});
      offer(req_type'{MODE_WRITE, 11'd49, 8'hFF});
      offer(req_type'{MODE_WRITE, 11'd63, 8'h7E});
      repeat (5) offer(req_type'{MODE_EMIT, 11'd0, 8'h00});
      offer(req_type'{MODE_SWAP, 11'd2047, 8'hFF});
      offer(req_type'{MODE_UNUSED, 11'd48, 8'h33});
      repeat (4) offer(req_type'{MODE_EMIT, 11'h7FF, 8'hFF});
      offer(req_type'{MODE_WRITE, 11'd60, 8'hC3});
      repeat (3) offer(req_type'{MODE_EMIT, 11'd0, 8'h00});

      for (int p = 0; p < PHASES; p++) begin
         settle();
         configure(4'(phase_wide[p]), 4'(phase_high[p]), 4'(phase_dbl[p]));
         eff_w = (phase_wide[p] == 0) ? 1 : (phase_wide[p] > 8 ? 8 : phase_wide[p]);
         eff_h = phase_high[p] % 8;
         eff_h = (eff_h == 0) ? 1 : (eff_h > 4 ? 4 : eff_h);
         dbl = 1'(phase_dbl[p] % 2);
         hold_requests++;
         done_items = 0;
         while (done_items < phase_items[p]) begin
            t = make_item(eff_w * 4 * eff_h * PANEL_ROWS);
            offer(t);
            if (t.mode != MODE_UNUSED && !(t.mode == MODE_SWAP && !dbl)) done_items++;
         end
      end
      settle();

      if (mismatches == 0 && outstanding == 0) begin
         $display("led_panel_quarter_scan_out test passed");
      end else begin
         $display("led_panel_quarter_scan_out test failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lpqs_pkg.sv
rtl/core/led_panel_quarter_scan_out.sv
bench/lpqs_scan_checker.sv
bench/testbench.sv
